// File: src/four_register_cpu_execute_top_macros.svh
// Assertion macros for the four register execute block
`ifndef FOUR_REGISTER_CPU_EXECUTE_TOP_MACROS_SVH
`define FOUR_REGISTER_CPU_EXECUTE_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FCX_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FCX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCX_ASSERT_IMPL(lbl, ante, cons, msg)
`define FCX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/fcx_pkg.sv
// Package: payload types, control structs and codes for the execute block
`timescale 1ns / 1ps
package fcx_pkg;

    // opcodes
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_MOV  = 8'h01;
    localparam logic [7:0] OP_ADD  = 8'h02;
    localparam logic [7:0] OP_SUB  = 8'h03;
    localparam logic [7:0] OP_MUL  = 8'h04;
    localparam logic [7:0] OP_DIV  = 8'h05;
    localparam logic [7:0] OP_XOR  = 8'h06;
    localparam logic [7:0] OP_OR   = 8'h07;
    localparam logic [7:0] OP_AND  = 8'h08;
    localparam logic [7:0] OP_HLT  = 8'h09;
    localparam logic [7:0] OP_PUSH = 8'h0A;
    localparam logic [7:0] OP_POP  = 8'h0B;
    localparam logic [7:0] OP_STO  = 8'h0C;
    localparam logic [7:0] OP_GET  = 8'h0D;
    localparam logic [7:0] OP_END  = 8'hFF;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HALTED    = 3'd1;
    localparam logic [2:0] ST_END       = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_BADREG    = 3'd4;
    localparam logic [2:0] ST_BADADDR   = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;
    localparam logic [2:0] ST_UNDERFLOW = 3'd7;

    typedef struct packed {
        logic [7:0]         req_type;
        logic signed [31:0] arg_first;
        logic signed [31:0] arg_second;
        logic               arg_third;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               reg_written;
        logic [1:0]         reg_index;
        logic signed [31:0] reg_value;
        logic [9:0]         stack_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_instr;
        logic div_start;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: src/fcx_ctrl.sv
// Controller state machine: sequences capture, divide iterations and retire
`timescale 1ns / 1ps
`include "four_register_cpu_execute_top_macros.svh"
module fcx_ctrl
    import fcx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.load_instr = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FCX_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "accept did not start exec")
    `FCX_ASSERT_NEXT(a_div_end, state_reg == S_DIV && sts.div_last, state_reg == S_FIN,
        "divide did not retire")
    `FCX_ASSERT_NEXT(a_fin_hold, state_reg == S_FIN && !sts.out_free, state_reg == S_FIN,
        "retire left while output busy")
    `FCX_ASSERT_IMPL(a_finish_free, cmd.finish, sts.out_free, "retire into busy output")

endmodule

// File: src/fcx_dpath.sv
// Datapath: registers, stack and RAM memories, ALU, divider, output register
`timescale 1ns / 1ps
module fcx_dpath
    import fcx_pkg::*;
#(
    parameter int STACK_DEPTH = 512,
    parameter int RAM_DEPTH   = 2048
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      in_data,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    output logic      out_valid,
    input  logic      out_ready,
    output rsp_t      out_data
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int RAW = $clog2(RAM_DEPTH);

    req_t        instr_reg;
    logic [31:0] gp_reg [4];
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] ram_mem [RAM_DEPTH];
    logic [31:0] stk_rd_reg;
    logic [31:0] ram_rd_reg;
    logic [CW-1:0] depth_reg;
    logic          halted_reg;
    logic          out_valid_reg;
    rsp_t          out_reg;

    // divider state
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [4:0]  cnt_reg;

    logic [7:0]  op;
    logic [31:0] a1;
    logic [31:0] a2;
    logic        a1_ok;
    logic        a2_ok;
    logic        addr_ok;
    logic [31:0] d_val;
    logic [31:0] s_val;
    logic [31:0] push_val;
    logic [31:0] alu_r;
    logic [31:0] quo_fix;
    logic        is_alu;
    logic [CW-1:0] stk_top;
    logic [32:0] shifted;
    logic        ge;

    // result of retire
    logic [2:0]  st;
    logic        wr;
    logic [1:0]  widx;
    logic [31:0] wval;
    logic        do_push;
    logic        do_pop;
    logic        do_sto;
    logic        do_hlt;

    // decode
    assign op      = instr_reg.req_type;
    assign a1      = instr_reg.arg_first;
    assign a2      = instr_reg.arg_second;
    assign a1_ok   = (a1[31:2] == 30'd0);
    assign a2_ok   = (a2[31:2] == 30'd0);
    assign addr_ok = !a1[31] && (a1 < 32'(RAM_DEPTH));
    assign is_alu  = (op >= OP_MOV) && (op <= OP_AND);
    assign d_val   = a1_ok ? gp_reg[a1[1:0]] : 32'd0;
    assign s_val   = instr_reg.arg_third ? (a2_ok ? gp_reg[a2[1:0]] : 32'd0) : a2;
    assign push_val = (a2 != 32'd0) ? d_val : a1;
    assign stk_top = depth_reg - CW'(1);
    assign quo_fix = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    // ALU
    always_comb
    begin
        unique case (op)
            OP_MOV:  alu_r = s_val;
            OP_ADD:  alu_r = d_val + s_val;
            OP_SUB:  alu_r = d_val - s_val;
            OP_MUL:  alu_r = d_val * s_val;
            OP_DIV:  alu_r = quo_fix;
            OP_XOR:  alu_r = d_val ^ s_val;
            OP_OR:   alu_r = d_val | s_val;
            default: alu_r = d_val & s_val;
        endcase
    end

    // status and effects at retire
    always_comb
    begin
        st      = ST_OK;
        wr      = 1'b0;
        widx    = 2'd0;
        wval    = 32'd0;
        do_push = 1'b0;
        do_pop  = 1'b0;
        do_sto  = 1'b0;
        do_hlt  = 1'b0;
        priority if (halted_reg)
        begin
            st = ST_HALTED;
        end
        else if (is_alu)
        begin
            priority if (!a1_ok)
                st = ST_BADREG;
            else if (op == OP_DIV && s_val == 32'd0)
                st = ST_DIVZERO;
            else
            begin
                wr   = 1'b1;
                widx = a1[1:0];
                wval = alu_r;
            end
        end
        else if (op == OP_HLT)
        begin
            st     = ST_HALTED;
            do_hlt = 1'b1;
        end
        else if (op == OP_PUSH)
        begin
            if (depth_reg >= CW'(STACK_DEPTH))
                st = ST_OVERFLOW;
            else
                do_push = 1'b1;
        end
        else if (op == OP_POP)
        begin
            priority if (!a1_ok)
                st = ST_BADREG;
            else if (depth_reg == '0)
                st = ST_UNDERFLOW;
            else
            begin
                do_pop = 1'b1;
                wr     = 1'b1;
                widx   = a1[1:0];
                wval   = stk_rd_reg;
            end
        end
        else if (op == OP_STO)
        begin
            if (!addr_ok)
                st = ST_BADADDR;
            else
                do_sto = 1'b1;
        end
        else if (op == OP_GET)
        begin
            priority if (!a2_ok)
                st = ST_BADREG;
            else if (!addr_ok)
                st = ST_BADADDR;
            else
            begin
                wr   = 1'b1;
                widx = a2[1:0];
                wval = ram_rd_reg;
            end
        end
        else if (op == OP_END)
        begin
            st = ST_END;
        end
    end

    // status to controller
    assign sts.need_div = !halted_reg && (op == OP_DIV) && a1_ok && (s_val != 32'd0);
    assign sts.div_last = (cnt_reg == 5'd31);
    assign sts.out_free = !out_valid_reg || out_ready;

    // divider step: one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[31]};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= d_val[31] ? (32'd0 - d_val) : d_val;
            rem_reg <= 32'd0;
            dvs_reg <= s_val[31] ? (32'd0 - s_val) : s_val;
            neg_reg <= d_val[31] ^ s_val[31];
            cnt_reg <= 5'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
            quo_reg <= {quo_reg[30:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // instruction capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_instr)
        begin
            instr_reg <= in_data;
        end
    end

    // memories: registered reads, writes at retire
    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stack_mem[stk_top[SAW-1:0]];
        ram_rd_reg <= ram_mem[a1[RAW-1:0]];
        if (cmd.finish && do_push)
        begin
            stack_mem[depth_reg[SAW-1:0]] <= push_val;
        end
        if (cmd.finish && do_sto)
        begin
            ram_mem[a1[RAW-1:0]] <= s_val;
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg[0]  <= 32'd0;
            gp_reg[1]  <= 32'd0;
            gp_reg[2]  <= 32'd0;
            gp_reg[3]  <= 32'd0;
            depth_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (wr)
                gp_reg[widx] <= wval;
            if (do_push)
                depth_reg <= depth_reg + CW'(1);
            else if (do_pop)
                depth_reg <= stk_top;
            if (do_hlt)
                halted_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.status      <= st;
            out_reg.reg_written <= wr;
            out_reg.reg_index   <= widx;
            out_reg.reg_value   <= wval;
            out_reg.stack_count <= do_push ? 10'(depth_reg + CW'(1))
                                 : (do_pop ? 10'(stk_top) : 10'(depth_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: src/four_register_cpu_execute_top.sv
// Top level of the four register execute block
//
//  channel   | signals                      | carries
//  ----------+------------------------------+---------------------------
//  in        | in_valid, in_ready, in_data  | one instruction (req_t)
//  out       | out_valid, out_ready, out_data | one result (rsp_t)
//
// One instruction at a time: capture, execute, retire.
// DIV adds a bit-serial divide phase between execute and retire.
// Memory reads are registered; POP and GET data is ready at retire.
// Retire waits while the output register holds an untaken result.
// Reset clears registers, stack depth and halt; stack and RAM stay unset.
`timescale 1ns / 1ps
module four_register_cpu_execute_top
    import fcx_pkg::*;
#(
    parameter int STACK_DEPTH = 512,
    parameter int RAM_DEPTH   = 2048
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    fcx_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fcx_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .RAM_DEPTH   (RAM_DEPTH)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: sim/tb.sv
// Testbench for the four register execute block: random and directed instructions
`timescale 1ns / 1ps
module tb;
    import fcx_pkg::*;

    localparam int STACK_MAX = 512;
    localparam int RAM_WORDS = 2048;
    localparam int RAM_TRACK = 64;    // random stores and loads mostly stay in a low window

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    four_register_cpu_execute_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // machine state as the checker sees it
    logic [31:0] gp_model [4];
    logic [31:0] stack_model [STACK_MAX];
    logic [31:0] ram_model [RAM_WORDS];
    bit          ram_written [RAM_WORDS];
    int          depth_model;
    bit          halt_model;

    rsp_t expected_results [$];
    int   mismatches;
    int   sent_count;
    int   burst_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] source_value(logic [31:0] arg, logic from_reg);
        if (!from_reg)
            return arg;
        if ($signed(arg) >= 0 && $signed(arg) <= 3)
            return gp_model[arg[1:0]];
        return 32'd0;
    endfunction

    function automatic bit reg_in_range(logic [31:0] idx);
        return $signed(idx) >= 0 && $signed(idx) <= 3;
    endfunction

    // execute one instruction on the state copy and return its result
    function automatic rsp_t execute_instr(req_t r);
        rsp_t        res;
        logic [31:0] d, s, v;
        logic [63:0] prod;
        bit          ok;
        res = '0;
        res.status = ST_OK;
        if (halt_model)
            res.status = ST_HALTED;
        else if (r.req_type >= OP_MOV && r.req_type <= OP_AND)
        begin
            if (!reg_in_range(r.arg_first))
                res.status = ST_BADREG;
            else
            begin
                d = gp_model[r.arg_first[1:0]];
                s = source_value(r.arg_second, r.arg_third);
                ok = 1;
                case (r.req_type)
                    OP_MOV: v = s;
                    OP_ADD: v = d + s;
                    OP_SUB: v = d - s;
                    OP_MUL:
                    begin
                        prod = {32'd0, d} * {32'd0, s};
                        v = prod[31:0];
                    end
                    OP_DIV:
                    begin
                        if (s == 0)
                            ok = 0;
                        else if (d == 32'h8000_0000 && s == 32'hFFFF_FFFF)
                            v = d;
                        else
                            v = $signed(d) / $signed(s);
                    end
                    OP_XOR: v = d ^ s;
                    OP_OR:  v = d | s;
                    default: v = d & s;
                endcase
                if (ok)
                begin
                    gp_model[r.arg_first[1:0]] = v;
                    res.reg_written = 1;
                    res.reg_index = r.arg_first[1:0];
                    res.reg_value = v;
                end
                else
                    res.status = ST_DIVZERO;
            end
        end
        else if (r.req_type == OP_HLT)
        begin
            halt_model = 1;
            res.status = ST_HALTED;
        end
        else if (r.req_type == OP_PUSH)
        begin
            if (depth_model >= STACK_MAX)
                res.status = ST_OVERFLOW;
            else
            begin
                stack_model[depth_model] = source_value(r.arg_first, r.arg_second != 0);
                depth_model++;
            end
        end
        else if (r.req_type == OP_POP)
        begin
            if (!reg_in_range(r.arg_first))
                res.status = ST_BADREG;
            else if (depth_model == 0)
                res.status = ST_UNDERFLOW;
            else
            begin
                depth_model--;
                v = stack_model[depth_model];
                gp_model[r.arg_first[1:0]] = v;
                res.reg_written = 1;
                res.reg_index = r.arg_first[1:0];
                res.reg_value = v;
            end
        end
        else if (r.req_type == OP_STO)
        begin
            if ($signed(r.arg_first) < 0 || $signed(r.arg_first) >= RAM_WORDS)
                res.status = ST_BADADDR;
            else
            begin
                ram_model[r.arg_first] = source_value(r.arg_second, r.arg_third);
                ram_written[r.arg_first] = 1;
            end
        end
        else if (r.req_type == OP_GET)
        begin
            if (!reg_in_range(r.arg_second))
                res.status = ST_BADREG;
            else if ($signed(r.arg_first) < 0 || $signed(r.arg_first) >= RAM_WORDS)
                res.status = ST_BADADDR;
            else
            begin
                v = ram_model[r.arg_first];
                gp_model[r.arg_second[1:0]] = v;
                res.reg_written = 1;
                res.reg_index = r.arg_second[1:0];
                res.reg_value = v;
            end
        end
        else if (r.req_type == OP_END)
            res.status = ST_END;
        res.stack_count = depth_model[9:0];
        return res;
    endfunction

    // send one instruction, with bursts and gaps between them
    task automatic send_instr(req_t r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= r;
        expected_results.push_back(execute_instr(r));
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    function automatic req_t make_instr(logic [7:0] op, logic [31:0] a1, logic [31:0] a2,
                                        logic a3);
        req_t r;
        r.req_type = op;
        r.arg_first = a1;
        r.arg_second = a2;
        r.arg_third = a3;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // register index, sometimes out of range
    function automatic logic [31:0] rand_reg();
        if ($urandom_range(0, 9) == 0)
            return rand_word();
        return $urandom_range(0, 3);
    endfunction

    // result receiver with its own stall pattern
    initial
    begin
        int phase;
        rsp_t exp_r;
        out_ready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_data !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_r, out_data);
                    end
                end
            end
            phase++;
            if (phase % 200 < 60)
                out_ready <= 1'b1;
            else
                out_ready <= ((phase % 7) != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    task automatic test_directed();
        send_instr(make_instr(OP_MOV, 0, 32'h8000_0000, 1'b0));
        send_instr(make_instr(OP_MOV, 1, 32'hFFFF_FFFF, 1'b0));
        send_instr(make_instr(OP_DIV, 0, 1, 1'b1));            // divide overflow
        send_instr(make_instr(OP_ADD, 0, 32'h7FFF_FFFF, 1'b0));
        send_instr(make_instr(OP_SUB, 2, 32'h8000_0000, 1'b0));
        send_instr(make_instr(OP_MUL, 1, 32'h7FFF_FFFF, 1'b0));
        send_instr(make_instr(OP_DIV, 2, 0, 1'b0));            // divide by zero
        send_instr(make_instr(OP_DIV, 1, 32'hFFFF_FFF9, 1'b0));
        send_instr(make_instr(OP_XOR, 3, 2, 1'b1));
        send_instr(make_instr(OP_OR, 3, 32'hFFFF_FFFF, 1'b1)); // source index out of range
        send_instr(make_instr(OP_AND, 3, 32'h0F0F_0F0F, 1'b0));
        send_instr(make_instr(OP_MOV, 4, 1, 1'b0));            // bad destination
        send_instr(make_instr(OP_MOV, 32'h8000_0000, 1, 1'b0));
        send_instr(make_instr(OP_POP, 0, 0, 1'b0));            // stack empty
        send_instr(make_instr(OP_PUSH, 3, 1, 1'b0));
        send_instr(make_instr(OP_PUSH, 32'hDEAD_BEEF, 0, 1'b0));
        send_instr(make_instr(OP_POP, 5, 0, 1'b0));
        send_instr(make_instr(OP_POP, 2, 0, 1'b0));
        send_instr(make_instr(OP_STO, RAM_WORDS - 1, 32'h1234_5678, 1'b0));
        send_instr(make_instr(OP_STO, RAM_WORDS, 0, 1'b0));    // bad address
        send_instr(make_instr(OP_STO, 32'hFFFF_FFFF, 0, 1'b0));
        send_instr(make_instr(OP_GET, RAM_WORDS - 1, 1, 1'b0));
        send_instr(make_instr(OP_GET, RAM_WORDS - 1, 7, 1'b0)); // bad register, valid address
        send_instr(make_instr(OP_END, 0, 0, 1'b0));
        send_instr(make_instr(8'h77, 0, 0, 1'b0));             // unknown opcode
    endtask

    // fill the stack to the top and drain it below empty
    task automatic test_stack_limits();
        while (depth_model < STACK_MAX)
            send_instr(make_instr(OP_PUSH, $urandom, 0, 1'b0));
        send_instr(make_instr(OP_PUSH, 1, 0, 1'b0));
        while (depth_model > 0)
            send_instr(make_instr(OP_POP, $urandom_range(0, 3), 0, 1'b0));
        send_instr(make_instr(OP_POP, 1, 0, 1'b0));
    endtask

    task automatic test_random(int count);
        logic [7:0]  op;
        logic [31:0] addr;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    op = 8'($urandom_range(OP_MOV, OP_AND));
                8, 9:   op = OP_PUSH;
                10, 11: op = OP_POP;
                12, 13: op = OP_STO;
                14, 15: op = OP_GET;
                16:     op = OP_END;
                17:     op = OP_NOP;
                18:     op = 8'($urandom_range(14, 254));
                default: op = 8'($urandom_range(0, 255));
            endcase
            if (op == OP_HLT)
                op = OP_NOP;
            addr = $urandom_range(0, RAM_TRACK - 1);
            if (op == OP_GET)
            begin
                // never read a word that was not stored
                if ($urandom_range(0, 9) == 0)
                    send_instr(make_instr(op, rand_word() | 32'h8000_0000,
                                          rand_reg(), 1'($urandom)));
                else if (ram_written[addr])
                    send_instr(make_instr(op, addr, rand_reg(), 1'($urandom)));
                else
                    send_instr(make_instr(OP_STO, addr, rand_word(), 1'($urandom)));
            end
            else if (op == OP_STO)
                send_instr(make_instr(op, ($urandom_range(0, 9) == 0) ? rand_word() : addr,
                                      rand_word(), 1'($urandom)));
            else if (op == OP_PUSH)
                send_instr(make_instr(op, rand_word(), $urandom_range(0, 1) ? rand_word() : 0,
                                      1'($urandom)));
            else
                send_instr(make_instr(op, rand_reg(), rand_word(), 1'($urandom)));
        end
    endtask

    task automatic test_halt();
        send_instr(make_instr(OP_HLT, 0, 0, 1'b0));
        send_instr(make_instr(OP_MOV, 0, 5, 1'b0));
        send_instr(make_instr(OP_PUSH, 1, 0, 1'b0));
        send_instr(make_instr(OP_HLT, 0, 0, 1'b0));
        send_instr(make_instr(OP_END, 0, 0, 1'b0));
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        sent_count = 0;
        burst_left = 0;
        depth_model = 0;
        halt_model = 0;
        for (int i = 0; i < 4; i++)
            gp_model[i] = '0;
        for (int i = 0; i < RAM_WORDS; i++)
            ram_written[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_stack_limits();
        test_random(450);
        test_halt();
        in_valid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/fcx_pkg.sv
src/fcx_ctrl.sv
src/fcx_dpath.sv
src/four_register_cpu_execute_top.sv
sim/tb.sv
